// ===== src/icv_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the streaming 3x3 convolution core.
// No dependencies; icv_cell, icv_out_fifo and the core import this package.
package icv_pkg;

	localparam int PIXEL_BITS     = 16;
	localparam int WEIGHT_BITS    = 5;
	localparam int TAPS           = 9;
	localparam int KERNEL_BITS    = TAPS * WEIGHT_BITS;
	localparam int WIDTH_REG_BITS = 9;
	localparam int CFG_DATA_BITS  = KERNEL_BITS;
	localparam int CFG_INDEX_BITS = 1;
	localparam int VALUE_BITS     = 24;
	localparam int COORD_BITS     = 8;
	localparam int PROD_BITS      = PIXEL_BITS + WEIGHT_BITS;
	localparam int ROW_SUM_BITS   = PROD_BITS + 2;
	localparam int TOTAL_BITS     = ROW_SUM_BITS + 2;
	localparam int MIN_WIDTH      = 3;
	localparam int FIFO_DEPTH     = 8;

	// Edge kernel -1 0 1 / -2 0 2 / -1 0 1.
	localparam logic [KERNEL_BITS-1:0]    KERNEL_RESET = 45'd1132865717279;
	localparam logic [WIDTH_REG_BITS-1:0] WIDTH_RESET  = 9'd256;

	localparam logic [CFG_INDEX_BITS-1:0] REG_KERNEL = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_WIDTH  = 1'b1;

	typedef logic signed [PIXEL_BITS-1:0]  pix_t;
	typedef logic signed [WEIGHT_BITS-1:0] weight_t;
	typedef logic signed [PROD_BITS-1:0]   prod_t;

	typedef struct packed {
		pix_t pixel;
		logic frame_start;
	} in_t;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] conv_value;
		logic [COORD_BITS-1:0]        out_row;
		logic [COORD_BITS-1:0]        out_col;
	} out_t;

endpackage

// ===== src/icv_line_store.sv =====
`timescale 1ns / 1ps
// One line store: a single-port-per-side memory with a registered read.
// Depends on nothing but its parameters.
module icv_line_store #(
	parameter int DEPTH     = 256,
	parameter int DATA_BITS = 16,
	localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr,
	output logic [DATA_BITS-1:0] rd_data,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  logic [DATA_BITS-1:0] wr_data
);

	logic [DATA_BITS-1:0] mem [DEPTH];
	logic [DATA_BITS-1:0] rd_data_q;

	// A read and a write at the same address in one cycle return the old entry.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== src/icv_cell.sv =====
`timescale 1ns / 1ps
// One window cell: holds a pixel, passes it to its left neighbour on a shift
// and registers its weighted product. Depends on icv_pkg.
module icv_cell
	import icv_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    shift,
	input  pix_t    pix_in,
	input  weight_t weight,
	output pix_t    pix,
	output prod_t   prod
);

	pix_t  pix_q;
	prod_t prod_d;
	prod_t prod_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_q <= '0;
		end else if (shift) begin
			pix_q <= pix_in;
		end
	end

	assign prod_d = $signed(PROD_BITS'(pix_q)) * $signed(PROD_BITS'(weight));

	always_ff @(posedge clk) begin
		prod_s3 <= prod_d;
	end

	assign pix  = pix_q;
	assign prod = prod_s3;

endmodule

// ===== src/icv_out_fifo.sv =====
`timescale 1ns / 1ps
// Small result queue between the adder pipeline and the output channel.
// Depends on icv_pkg for the result type and the depth.
module icv_out_fifo
	import icv_pkg::*;
#(
	localparam int PW = $clog2(FIFO_DEPTH),
	localparam int CW = $clog2(FIFO_DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  out_t          push_data,
	output logic          out_valid,
	input  logic          out_ready,
	output out_t          out_data,
	output logic [CW-1:0] level
);

	out_t          mem [FIFO_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          pop;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;
	assign out_data  = mem[rd_ptr_q];
	assign level     = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== src/image_conv3x3_stream_core.sv =====
`timescale 1ns / 1ps
// Streaming 3x3 convolution: line stores, a 3x3 array of window cells, adder pipeline.
// One pixel per cycle unless stalled; a completed window's result passes the stage-1
// registers, the window cells and the product and row-sum registers. Input stalls only
// while queued and in-flight results fill the eight-entry result queue. Reset restores
// the kernel and width registers and clears the raster position and window; the line stores are not cleared.
// Depends on icv_pkg, icv_line_store, icv_cell and icv_out_fifo.
module image_conv3x3_stream_core
	import icv_pkg::*;
#(
	parameter int MAX_WIDTH = 256
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  in_t                       in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output out_t                      out_data,
	input  logic                      cfg_wr_en,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int CW       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int EW       = (CW + 1 > WIDTH_REG_BITS) ? CW + 1 : WIDTH_REG_BITS;
	localparam int LVL_BITS = $clog2(FIFO_DEPTH + 1);
	localparam int SUM_BITS = LVL_BITS + 1;

	logic [KERNEL_BITS-1:0]    kernel_q;
	logic [WIDTH_REG_BITS-1:0] width_q;
	logic [CW-1:0]             row_q;
	logic [CW-1:0]             col_q;

	logic          take;
	logic [CW-1:0] cur_r;
	logic [CW-1:0] cur_c;
	logic [EW-1:0] width_ext;
	logic [EW-1:0] eff_w;
	logic [EW-1:0] col_inc;
	logic [EW-1:0] row_inc;

	logic          valid_s1, emit_s1, byp_s1;
	pix_t          px_s1, byp_data_s1;
	logic [CW-1:0] r_s1, c_s1;
	pix_t          a_rd, b_rd;

	logic                  emit_s2, emit_s3, emit_s4;
	logic [COORD_BITS-1:0] row_s2, col_s2, row_s3, col_s3, row_s4, col_s4;

	pix_t    new_col [3];
	pix_t    win     [3][3];
	prod_t   prod    [3][3];
	weight_t wgt     [3][3];
	logic signed [ROW_SUM_BITS-1:0] row_sum_s4 [3];
	logic signed [TOTAL_BITS-1:0]   total;

	logic [2:0]          inflight;
	logic [LVL_BITS-1:0] fifo_level;
	out_t                push_data;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_q <= KERNEL_RESET;
			width_q  <= WIDTH_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_KERNEL: kernel_q <= cfg_data[KERNEL_BITS-1:0];
				REG_WIDTH:  width_q  <= cfg_data[WIDTH_REG_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Raster position of the incoming request and its successor.
	assign take      = in_valid && in_ready;
	assign cur_r     = in_data.frame_start ? '0 : row_q;
	assign cur_c     = in_data.frame_start ? '0 : col_q;
	assign width_ext = EW'(width_q);

	always_comb begin
		if (width_ext < EW'(MIN_WIDTH)) begin
			eff_w = EW'(MIN_WIDTH);
		end else if (width_ext > EW'(MAX_WIDTH)) begin
			eff_w = EW'(MAX_WIDTH);
		end else begin
			eff_w = width_ext;
		end
	end

	assign col_inc = EW'(cur_c) + EW'(1);
	assign row_inc = EW'(cur_r) + EW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (take) begin
			if (col_inc >= eff_w) begin
				col_q <= '0;
				row_q <= (row_inc >= eff_w) ? '0 : row_inc[CW-1:0];
			end else begin
				col_q <= col_inc[CW-1:0];
				row_q <= cur_r;
			end
		end
	end

	// Line stores: store a keeps the previous row, store b the one before it.
	icv_line_store #(
		.DEPTH     (MAX_WIDTH),
		.DATA_BITS (PIXEL_BITS)
	) u_store_a (
		.clk     (clk),
		.rd_en   (take),
		.rd_addr (cur_c),
		.rd_data (a_rd),
		.wr_en   (take),
		.wr_addr (cur_c),
		.wr_data (in_data.pixel)
	);

	// Store b is written in the cycle after the read, with the old entry of store a.
	icv_line_store #(
		.DEPTH     (MAX_WIDTH),
		.DATA_BITS (PIXEL_BITS)
	) u_store_b (
		.clk     (clk),
		.rd_en   (take),
		.rd_addr (cur_c),
		.rd_data (b_rd),
		.wr_en   (valid_s1),
		.wr_addr (c_s1),
		.wr_data (a_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			emit_s1  <= 1'b0;
			emit_s2  <= 1'b0;
			emit_s3  <= 1'b0;
			emit_s4  <= 1'b0;
		end else begin
			valid_s1 <= take;
			emit_s1  <= take && (cur_r >= CW'(2)) && (cur_c >= CW'(2));
			emit_s2  <= emit_s1;
			emit_s3  <= emit_s2;
			emit_s4  <= emit_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			px_s1 <= in_data.pixel;
			r_s1  <= cur_r;
			c_s1  <= cur_c;
			// The store b write still pending for this column has not landed yet.
			byp_s1      <= valid_s1 && (c_s1 == cur_c);
			byp_data_s1 <= a_rd;
		end
		row_s2 <= COORD_BITS'(r_s1 - CW'(1));
		col_s2 <= COORD_BITS'(c_s1 - CW'(1));
		row_s3 <= row_s2;
		col_s3 <= col_s2;
		row_s4 <= row_s3;
		col_s4 <= col_s3;
	end

	assign new_col[0] = byp_s1 ? byp_data_s1 : b_rd;
	assign new_col[1] = a_rd;
	assign new_col[2] = px_s1;

	// Window cells: each row is a chain shifting towards column zero.
	for (genvar i = 0; i < 3; i++) begin : g_row
		for (genvar j = 0; j < 3; j++) begin : g_col
			pix_t pix_in;
			if (j == 2) begin : g_edge
				assign pix_in = new_col[i];
			end else begin : g_inner
				assign pix_in = win[i][j+1];
			end
			assign wgt[i][j] = $signed(kernel_q[(i*3+j)*WEIGHT_BITS +: WEIGHT_BITS]);

			icv_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (valid_s1),
				.pix_in (pix_in),
				.weight (wgt[i][j]),
				.pix    (win[i][j]),
				.prod   (prod[i][j])
			);
		end

		always_ff @(posedge clk) begin
			row_sum_s4[i] <= ROW_SUM_BITS'(prod[i][0]) + ROW_SUM_BITS'(prod[i][1])
				+ ROW_SUM_BITS'(prod[i][2]);
		end
	end

	assign total = TOTAL_BITS'(row_sum_s4[0]) + TOTAL_BITS'(row_sum_s4[1])
		+ TOTAL_BITS'(row_sum_s4[2]);

	assign push_data.conv_value = total[VALUE_BITS-1:0];
	assign push_data.out_row    = row_s4;
	assign push_data.out_col    = col_s4;

	icv_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (emit_s4),
		.push_data (push_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.level     (fifo_level)
	);

	// Take a request only while the queue has room for every result in flight.
	assign inflight = 3'(emit_s1) + 3'(emit_s2) + 3'(emit_s3) + 3'(emit_s4);
	assign in_ready = (SUM_BITS'(fifo_level) + SUM_BITS'(inflight)) < SUM_BITS'(FIFO_DEPTH);

endmodule
